FILE: rtl/core/slist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slist_pkg;

    localparam int CMD_W            = 3;
    localparam int VALUE_W          = 32;
    localparam int POS_W            = 5;
    localparam int STATUS_W         = 2;
    localparam int COUNT_W          = 5;
    localparam int DEFAULT_CAPACITY = 16;

    typedef logic [CMD_W-1:0]           cmd_t;
    typedef logic signed [VALUE_W-1:0]  data_t;
    typedef logic [POS_W-1:0]           pos_t;
    typedef logic [STATUS_W-1:0]        status_t;
    typedef logic [COUNT_W-1:0]         count_t;

    localparam cmd_t CMD_PUSH_BACK  = 3'd0;
    localparam cmd_t CMD_POP_BACK   = 3'd1;
    localparam cmd_t CMD_PUSH_FRONT = 3'd2;
    localparam cmd_t CMD_POP_FRONT  = 3'd3;
    localparam cmd_t CMD_INSERT     = 3'd4;
    localparam cmd_t CMD_DUMP       = 3'd5;

    localparam status_t STAT_OK     = 2'd0;
    localparam status_t STAT_FULL   = 2'd1;
    localparam status_t STAT_EMPTY  = 2'd2;
    localparam status_t STAT_BADPOS = 2'd3;

    // Per-cell load select
    typedef logic [2:0] cell_op_t;

    localparam cell_op_t CELL_HOLD       = 3'd0;
    localparam cell_op_t CELL_LOAD_VALUE = 3'd1;
    localparam cell_op_t CELL_FROM_LEFT  = 3'd2;
    localparam cell_op_t CELL_FROM_RIGHT = 3'd3;
    localparam cell_op_t CELL_FROM_HEAD  = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/core/slist_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module slist_cell (
    input  wire                   clk,
    input  slist_pkg::cell_op_t   op,
    input  slist_pkg::data_t      value,
    input  slist_pkg::data_t      left_data,
    input  slist_pkg::data_t      right_data,
    input  slist_pkg::data_t      head_data,
    output slist_pkg::data_t      data
);
    import slist_pkg::*;

    data_t data_reg;
    data_t data_next;

    always_comb
    begin
        case (op)
            CELL_HOLD:       data_next = data_reg;
            CELL_LOAD_VALUE: data_next = value;
            CELL_FROM_LEFT:  data_next = left_data;
            CELL_FROM_RIGHT: data_next = right_data;
            CELL_FROM_HEAD:  data_next = head_data;
            default:         data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sequential_list_insert_remove.sv
// Ordered list held in a row of CAPACITY register cells.
// Push, pop and insert: one item per cycle unless out_stall holds it; the result is
// registered in the cycle after accept. Dump: input stalls until the last element is
// out, one element per cycle unless out_stall holds it; an empty list gives one
// result. The head is read out while occupied cells rotate, so the list is intact
// after. Reset clears the fill count and output valid; cell contents are not reset.
`timescale 1ns / 1ps
`default_nettype none

module sequential_list_insert_remove #(
    parameter int CAPACITY = slist_pkg::DEFAULT_CAPACITY
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_stall,
    input  slist_pkg::cmd_t      cmd,
    input  slist_pkg::data_t     value,
    input  slist_pkg::pos_t      position,
    output logic                 out_valid,
    input  wire                  out_stall,
    output slist_pkg::status_t   status,
    output slist_pkg::data_t     element,
    output slist_pkg::count_t    count,
    output logic                 last
);
    import slist_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic            state_reg, state_next;
    logic [CW-1:0]   fill_reg, fill_next;
    logic [CW-1:0]   dcnt_reg, dcnt_next;
    logic            out_valid_reg, out_valid_next;
    status_t         status_reg, status_next;
    data_t           element_reg, element_next;
    count_t          count_reg, count_next;
    logic            last_reg, last_next;

    logic            out_free;
    logic            in_acc;
    logic            dump_step;
    logic            out_load;
    logic            is_full;
    logic            is_empty;
    logic [CW-1:0]   fill_m1;
    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] fill_p1;
    logic [CMPW-1:0] ins_k;
    logic            ins_en;
    logic            shift_en;
    logic            rot_en;

    data_t           cell_data [CAPACITY];
    cell_op_t        cell_op   [CAPACITY];

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg == S_DUMP) || !out_free;
    assign in_acc    = in_valid && !in_stall;
    assign dump_step = (state_reg == S_DUMP) && out_free;

    assign is_full  = (fill_reg == CW'(CAPACITY));
    assign is_empty = (fill_reg == '0);
    assign fill_m1  = fill_reg - 1'b1;
    assign pos_ext  = CMPW'(position);
    assign fill_p1  = CMPW'(fill_reg) + 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        dcnt_next    = dcnt_reg;
        out_load     = 1'b0;
        status_next  = STAT_OK;
        element_next = '0;
        last_next    = 1'b1;
        ins_en       = 1'b0;
        ins_k        = '0;
        shift_en     = 1'b0;
        rot_en       = 1'b0;

        if (in_acc)
        begin
            out_load = 1'b1;
            case (cmd)
                CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT:
                begin
                    if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else if (cmd == CMD_INSERT &&
                             (pos_ext == '0 || pos_ext > fill_p1))
                    begin
                        status_next = STAT_BADPOS;
                    end
                    else
                    begin
                        // every insert form: slot k takes the value, cells above move up
                        ins_en = 1'b1;
                        if (cmd == CMD_PUSH_BACK)
                            ins_k = CMPW'(fill_reg);
                        else if (cmd == CMD_INSERT)
                            ins_k = pos_ext - 1'b1;
                        else
                            ins_k = '0;
                        fill_next = fill_reg + 1'b1;
                    end
                end
                CMD_POP_BACK, CMD_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        shift_en  = (cmd == CMD_POP_FRONT);
                        fill_next = fill_m1;
                    end
                end
                CMD_DUMP:
                begin
                    if (!is_empty)
                    begin
                        out_load   = 1'b0;
                        state_next = S_DUMP;
                        dcnt_next  = '0;
                    end
                end
                default:
                begin
                    status_next = STAT_OK;
                end
            endcase
        end
        else if (dump_step)
        begin
            // emit head, rotate occupied cells by one
            out_load     = 1'b1;
            element_next = cell_data[0];
            rot_en       = 1'b1;
            last_next    = (dcnt_reg == fill_m1);
            if (dcnt_reg == fill_m1)
            begin
                state_next = S_IDLE;
                dcnt_next  = '0;
            end
            else
            begin
                dcnt_next = dcnt_reg + 1'b1;
            end
        end

        count_next     = COUNT_W'(fill_next);
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            localparam logic [CMPW-1:0] IDX_C = CMPW'(gi);
            localparam logic [CW-1:0]   IDX_F = CW'(gi);

            data_t left_d;
            data_t right_d;

            if (gi == 0)
            begin : g_first
                assign left_d = value;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = cell_data[0];
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end

            always_comb
            begin
                cell_op[gi] = CELL_HOLD;
                if (ins_en)
                begin
                    if (IDX_C == ins_k)
                        cell_op[gi] = CELL_LOAD_VALUE;
                    else if (IDX_C > ins_k)
                        cell_op[gi] = CELL_FROM_LEFT;
                end
                else if (shift_en)
                begin
                    cell_op[gi] = CELL_FROM_RIGHT;
                end
                else if (rot_en)
                begin
                    if (IDX_F == fill_m1)
                        cell_op[gi] = CELL_FROM_HEAD;
                    else if (IDX_F < fill_m1)
                        cell_op[gi] = CELL_FROM_RIGHT;
                end
            end

            slist_cell u_cell (
                .clk        (clk),
                .op         (cell_op[gi]),
                .value      (value),
                .left_data  (left_d),
                .right_data (right_d),
                .head_data  (cell_data[0]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload while the result waits
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg  <= status_next;
            element_reg <= element_next;
            count_reg   <= count_next;
            last_reg    <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign element   = element_reg;
    assign count     = count_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire
